[src/amcd_pkg.sv]
`timescale 1ns / 1ps
package amcd_pkg;
	localparam logic [9:0] DARK_SUM_RESET = 10'd765;
	localparam logic [23:0] WHITE_RGB = 24'hffffff;
	localparam logic [23:0] BLACK_RGB = 24'h000000;
	localparam logic [6:0] SIZE_RESET = 7'd16;
	localparam logic [0:0] REG_WIDTH = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	// 2x2 ordered dither threshold, indexed by x&1, y&1
	function automatic logic [1:0] dither_thr(input logic xb, input logic yb);
		logic [1:0] t;
		case ({xb, yb})
			2'b00: t = 2'd0;
			2'b01: t = 2'd2;
			2'b10: t = 2'd3;
			default: t = 2'd1;
		endcase
		return t;
	endfunction

	// up to 3 * 255^2, needs 18 bits
	function automatic logic [17:0] sq_dist(input logic [23:0] p, input logic [23:0] c);
		logic [17:0] s;
		logic [7:0] d;
		s = '0;
		for (int k = 0; k < 3; k++) begin
			d = (p[8*k +: 8] > c[8*k +: 8]) ? p[8*k +: 8] - c[8*k +: 8]
				: c[8*k +: 8] - p[8*k +: 8];
			s = s + 18'(d) * 18'(d);
		end
		return s;
	endfunction

	typedef struct packed {
		logic [23:0] dark;
		logic [23:0] bright;
		logic [6:0] rows;
		logic [6:0] cols;
	} job_t;
endpackage

[src/amcd_if.sv]
`timescale 1ns / 1ps
interface amcd_pix_if;
	logic valid;
	logic ready;
	logic [31:0] argb_pixel;
	modport source (output valid, output argb_pixel, input ready);
	modport sink (input valid, input argb_pixel, output ready);
endinterface

interface amcd_row_if;
	logic valid;
	logic ready;
	logic [63:0] shape_row;
	logic [63:0] mask_row;
	logic [23:0] fore_color;
	logic [23:0] back_color;
	logic last_row;
	modport source (output valid, output shape_row, output mask_row, output fore_color,
		output back_color, output last_row, input ready);
	modport sink (input valid, input shape_row, input mask_row, input fore_color,
		input back_color, input last_row, output ready);
endinterface

[src/amcd_ram.sv]
`timescale 1ns / 1ps
module amcd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[src/amcd_div.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle. q = num / den, num < 2^26.
module amcd_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [25:0] num,
	input logic [18:0] den,
	output logic busy,
	output logic done,
	output logic [25:0] quot
);
	logic [4:0] cnt_q;
	logic [18:0] rem_q;
	logic [25:0] q_q;
	logic [18:0] den_q;
	logic run_q;
	logic done_q;
	logic [19:0] trial;
	logic [19:0] shifted;

	assign shifted = {rem_q, q_q[25]};
	assign trial = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 5'd25;
			end else if (run_q) begin
				if (cnt_q == 5'd0) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			q_q <= num;
			den_q <= den;
		end else if (run_q) begin
			if (!trial[19]) begin
				rem_q <= trial[18:0];
				q_q <= {q_q[24:0], 1'b1};
			end else begin
				rem_q <= shifted[18:0];
				q_q <= {q_q[24:0], 1'b0};
			end
		end
	end

	assign busy = run_q;
	assign done = done_q;
	assign quot = q_q;
endmodule

[src/amcd_front.sv]
`timescale 1ns / 1ps
// Loads pixels into the store, tracks extreme colours, hands off a job per image.
module amcd_front #(
	parameter int MAX_WIDTH = 64,
	parameter int MAX_HEIGHT = 64
) (
	input logic clk,
	input logic arst_n,
	amcd_pix_if.sink pix,
	input logic [6:0] image_width,
	input logic [6:0] image_height,
	input logic restart,
	input logic job_full,
	output logic job_push,
	output amcd_pkg::job_t job,
	output logic we,
	output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] waddr,
	output logic [31:0] wdata
);
	localparam int AW = $clog2(MAX_WIDTH*MAX_HEIGHT);
	logic [AW:0] count_q;
	logic [9:0] bsum_q, dsum_q;
	logic [23:0] brgb_q, drgb_q;
	logic [6:0] w, h;
	logic [AW:0] total;
	logic [9:0] sum;
	logic acc, last;
	logic [9:0] nbsum, ndsum;
	logic [23:0] nbrgb, ndrgb;

	assign w = (image_width == 7'd0) ? 7'd1
		: (image_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : image_width;
	assign h = (image_height == 7'd0) ? 7'd1
		: (image_height > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : image_height;
	assign total = (AW+1)'(w * h);
	assign sum = 10'(pix.argb_pixel[23:16]) + 10'(pix.argb_pixel[15:8])
		+ 10'(pix.argb_pixel[7:0]);

	// stall while the job slot holds a finished image
	assign pix.ready = !job_full;
	assign acc = pix.valid && pix.ready;
	assign last = (count_q + 1'b1) == total;

	always_comb begin
		nbsum = bsum_q; nbrgb = brgb_q; ndsum = dsum_q; ndrgb = drgb_q;
		if (pix.argb_pixel[31:24] != 8'd0) begin
			if (sum > bsum_q) begin
				nbsum = sum; nbrgb = pix.argb_pixel[23:0];
			end
			if (sum < dsum_q) begin
				ndsum = sum; ndrgb = pix.argb_pixel[23:0];
			end
		end
	end

	assign we = acc;
	assign waddr = count_q[AW-1:0];
	assign wdata = pix.argb_pixel;
	assign job_push = acc && last;
	assign job = '{dark: ndrgb, bright: nbrgb, rows: h, cols: w};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			bsum_q <= '0;
			dsum_q <= amcd_pkg::DARK_SUM_RESET;
			brgb_q <= amcd_pkg::WHITE_RGB;
			drgb_q <= amcd_pkg::BLACK_RGB;
		end else if (restart || (acc && last)) begin
			count_q <= '0;
			bsum_q <= '0;
			dsum_q <= amcd_pkg::DARK_SUM_RESET;
			brgb_q <= amcd_pkg::WHITE_RGB;
			drgb_q <= amcd_pkg::BLACK_RGB;
		end else if (acc) begin
			count_q <= count_q + 1'b1;
			bsum_q <= nbsum; brgb_q <= nbrgb;
			dsum_q <= ndsum; drgb_q <= ndrgb;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) job_push |-> we);
	assert property (@(posedge clk) disable iff (!arst_n)
		job_push |=> count_q == '0);
	assert property (@(posedge clk) disable iff (!arst_n) count_q < total || restart
		|| $past(restart) || $changed(total));
endmodule

[src/amcd_back.sv]
`timescale 1ns / 1ps
// Walks the store row by row; one pixel per divide, a row result per image row.
module amcd_back #(
	parameter int MAX_WIDTH = 64,
	parameter int MAX_HEIGHT = 64
) (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	input amcd_pkg::job_t job,
	output logic job_pop,
	output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] raddr,
	input logic [31:0] rdata,
	amcd_row_if.source row
);
	localparam int AW = $clog2(MAX_WIDTH*MAX_HEIGHT);
	localparam logic [2:0] ST_IDLE = 3'd0, ST_READ = 3'd1, ST_WAIT = 3'd2,
		ST_DIV = 3'd3, ST_OUT = 3'd4;
	logic [2:0] st_q;
	logic [6:0] x_q, y_q;
	logic [AW-1:0] addr_q;
	logic [63:0] shape_q, mask_q;
	logic [31:0] pix_q;
	logic [1:0] thr;
	logic [17:0] d1, d2;
	logic [18:0] den;
	logic start, dbusy, ddone, sbit, mbit;
	logic [25:0] quot;
	logic [7:0] qv;
	logic [10:0] v5;

	assign thr = amcd_pkg::dither_thr(x_q[0], y_q[0]);
	assign d1 = amcd_pkg::sq_dist(pix_q[23:0], job.dark);
	assign d2 = amcd_pkg::sq_dist(pix_q[23:0], job.bright);
	assign den = 19'(d1) + 19'(d2);
	assign start = (st_q == ST_DIV) && !dbusy && !ddone && den != 19'd0;

	amcd_div u_div (.clk(clk), .arst_n(arst_n), .start(start),
		.num(26'(d2) * 26'd255), .den(den), .busy(dbusy), .done(ddone), .quot(quot));

	assign qv = quot[7:0];
	assign v5 = 11'(qv) * 11'd5;
	assign sbit = (den != 19'd0) && ddone && (v5[10:8] > 3'(thr));
	assign mbit = 3'((11'(pix_q[31:24]) * 11'd5) >> 8) > 3'(thr);

	assign raddr = addr_q;
	assign row.valid = st_q == ST_OUT;
	assign row.shape_row = shape_q;
	assign row.mask_row = mask_q;
	assign row.fore_color = job.dark;
	assign row.back_color = job.bright;
	assign row.last_row = (y_q + 7'd1) == job.rows;
	assign job_pop = row.valid && row.ready && row.last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			x_q <= '0; y_q <= '0; addr_q <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: if (job_valid) begin
					st_q <= ST_READ; x_q <= '0; y_q <= '0; addr_q <= '0;
				end
				ST_READ: st_q <= ST_WAIT;
				ST_WAIT: st_q <= ST_DIV;
				ST_DIV: if (den == 19'd0 || ddone) begin
					addr_q <= addr_q + 1'b1;
					if (x_q + 7'd1 == job.cols) begin
						st_q <= ST_OUT;
					end else begin
						x_q <= x_q + 7'd1; st_q <= ST_READ;
					end
				end
				ST_OUT: if (row.ready) begin
					x_q <= '0; y_q <= y_q + 7'd1;
					st_q <= row.last_row ? ST_IDLE : ST_READ;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_WAIT) begin
			pix_q <= rdata;
		end
		if (st_q == ST_READ && x_q == 7'd0) begin
			shape_q <= '0; mask_q <= '0;
		end
		if (st_q == ST_DIV && (den == 19'd0 || ddone)) begin
			shape_q[x_q[5:0]] <= sbit;
			mask_q[x_q[5:0]] <= mbit;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) row.valid |-> job_valid);
	assert property (@(posedge clk) disable iff (!arst_n) start |-> !dbusy);
	assert property (@(posedge clk) disable iff (!arst_n)
		(row.valid && !row.ready) |=> row.valid);
endmodule

[src/argb_to_mono_cursor_dither.sv]
`timescale 1ns / 1ps
// channel  | dir | payload
// pix      | in  | argb_pixel[31:0]
// row      | out | shape_row, mask_row, fore_color, back_color, last_row
// apb      | in  | image_width @0, image_height @4
// Pixels load at one per cycle while the image slot is free; the last
// pixel of an image hands a job to a single image slot. Each output row
// is built column by column, and the serial divider sets the rate.
// Reset is asynchronous, active low. Input stalls from the last pixel of
// an image until its last row transfer; the row port stalls the back end.
module argb_to_mono_cursor_dither #(
	parameter int MAX_WIDTH = 64,
	parameter int MAX_HEIGHT = 64
) (
	input logic clk,
	input logic arst_n,
	amcd_pix_if.sink pix,
	amcd_row_if.source row,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int AW = $clog2(MAX_WIDTH*MAX_HEIGHT);
	logic [6:0] width_q, height_q;
	logic wr, restart;
	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0] wdata, rdata;
	logic job_push, job_pop, job_full;
	amcd_pkg::job_t job_in;
	amcd_pkg::job_t fifo_q [2];
	logic rd_q, wp_q;
	logic [1:0] cnt_q;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite && paddr[1:0] == 2'b00;
	assign restart = wr;
	always_comb begin
		case (paddr[2])
			amcd_pkg::REG_WIDTH: prdata = {25'd0, width_q};
			default: prdata = {25'd0, height_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= amcd_pkg::SIZE_RESET;
			height_q <= amcd_pkg::SIZE_RESET;
		end else if (wr) begin
			if (paddr[2] == amcd_pkg::REG_WIDTH) width_q <= pwdata[6:0];
			else height_q <= pwdata[6:0];
		end
	end

	amcd_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk(clk), .arst_n(arst_n), .pix(pix), .image_width(width_q),
		.image_height(height_q), .restart(restart), .job_full(job_full),
		.job_push(job_push), .job(job_in), .we(we), .waddr(waddr), .wdata(wdata));

	amcd_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH*MAX_HEIGHT)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata));

	// a single image slot: the store holds one image at a time
	assign job_full = cnt_q != 2'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0; wp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (job_push) wp_q <= ~wp_q;
			if (job_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(job_push) - 2'(job_pop);
		end
	end
	always_ff @(posedge clk) begin
		if (job_push) fifo_q[wp_q] <= job_in;
	end

	amcd_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(cnt_q != 2'd0), .job(fifo_q[rd_q]),
		.job_pop(job_pop), .raddr(raddr), .rdata(rdata), .row(row));

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd1);
	assert property (@(posedge clk) disable iff (!arst_n) !(job_push && job_full));
	assert property (@(posedge clk) disable iff (!arst_n) job_pop |-> cnt_q != 2'd0);
endmodule
